### hdl/fbc_pkg.sv
// Package for the freed block cache: command and result codes, FSM states,
// controller/datapath interface structs. No dependencies.
package fbc_pkg;

  localparam int DefDepth       = 32;
  localparam int DefAddressBits = 48;
  localparam int SizeW          = 32;
  localparam int MaxW           = 6;
  localparam int CapCmpW        = 7;
  localparam int PaddrW         = 3;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HIT     = 2'd0,
    KIND_MISS    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_INPUT = 2'd1,
    SRC_ENTRY = 2'd2
  } src_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_EVICT  = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  typedef struct packed {
    logic  latch;
    logic  idx_clr;
    logic  idx_inc;
    logic  remove;
    logic  append;
    logic  clear_bytes;
    logic  emit;
    kind_e kind;
    src_e  src;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    logic qualifies;
    logic count_zero;
    logic must_evict;
    logic match;
    logic idx_last;
    logic room;
  } stat_t;

endpackage

### hdl/freed_block_cache.sv
// Top level of the freed block cache: APB config registers, controller and
// datapath. Depends on fbc_pkg, fbc_ctrl, fbc_dp.
//
//  channel   ports                                       handshake
//  command   start, command_i, block_*_i, has_*_i          start & !busy
//  result    result_*_o, last_result_o                   result_valid_o, 1 cycle
//  config    psel, penable, pwrite, paddr, pwdata, prdata  APB, pready high
//
// Result words are registered and leave in the cycle after they are made.
// Allocate gives a hit or miss word. Free releases a block that does not
// qualify, else each eviction, then done. Flush: each entry, then done.
// Reset empties the list and restores max 32, limit 4194304.
// The receiver cannot stall; busy holds off new commands.
module freed_block_cache #(
  parameter int Depth       = fbc_pkg::DefDepth,
  parameter int AddressBits = fbc_pkg::DefAddressBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [AddressBits-1:0]      block_address_i,
  input  logic [31:0]                 block_size_i,
  input  logic                        has_platform_pool_i,
  output logic                        result_valid_o,
  output logic [1:0]                  result_kind_o,
  output logic [AddressBits-1:0]      result_address_o,
  output logic [31:0]                 result_size_o,
  output logic                        last_result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbc_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fbc_pkg::*;

  logic [MaxW-1:0]  max_q;
  logic [SizeW-1:0] limit_q;
  ctrl_t            ctrl;
  stat_t            stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? limit_q : {{(32-MaxW){1'b0}}, max_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MaxW'(32);
      limit_q <= 32'd4194304;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) limit_q <= pwdata;
      else          max_q   <= pwdata[MaxW-1:0];
    end
  end

  fbc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy)
  );

  fbc_dp #(
    .Depth       (Depth),
    .AddressBits (AddressBits)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .block_address_i     (block_address_i),
    .block_size_i        (block_size_i),
    .has_platform_pool_i (has_platform_pool_i),
    .max_cached_blocks_i (max_q),
    .cached_byte_limit_i (limit_q),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .result_valid_o      (result_valid_o),
    .result_kind_o       (result_kind_o),
    .result_address_o    (result_address_o),
    .result_size_o       (result_size_o),
    .last_result_o       (last_result_o)
  );

endmodule

### hdl/fbc_ctrl.sv
// Controller FSM of the freed block cache: sequences search, eviction and
// flush over the datapath. Depends on fbc_pkg.
module fbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    command_i,
  input  fbc_pkg::stat_t stat_i,
  output fbc_pkg::ctrl_t ctrl_o,
  output logic          busy_o
);
  import fbc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.kind = KIND_DONE;
    ctrl_o.src  = SRC_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.latch   = 1'b1;
          ctrl_o.idx_clr = 1'b1;
          unique case (command_i)
            CMD_ALLOC: begin
              if (!stat_i.qualifies || stat_i.count_zero) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.kind = KIND_MISS;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            CMD_FREE: begin
              if (!stat_i.qualifies) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.kind = KIND_RELEASE;
                ctrl_o.src  = SRC_INPUT;
              end else begin
                state_d = ST_EVICT;
              end
            end
            CMD_FLUSH: state_d = ST_FLUSH;
            default:   ctrl_o.emit = 1'b1;
          endcase
        end
      end
      ST_SEARCH: begin
        if (stat_i.match) begin
          ctrl_o.emit   = 1'b1;
          ctrl_o.kind   = KIND_HIT;
          ctrl_o.src    = SRC_ENTRY;
          ctrl_o.remove = 1'b1;
          state_d       = ST_IDLE;
        end else if (stat_i.idx_last) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.kind = KIND_MISS;
          state_d     = ST_IDLE;
        end else begin
          ctrl_o.idx_inc = 1'b1;
        end
      end
      ST_EVICT: begin
        ctrl_o.emit = 1'b1;
        if (stat_i.must_evict) begin
          ctrl_o.kind   = KIND_RELEASE;
          ctrl_o.src    = SRC_ENTRY;
          ctrl_o.remove = 1'b1;
        end else begin
          ctrl_o.append = stat_i.room;
          state_d       = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        ctrl_o.emit = 1'b1;
        if (!stat_i.count_zero) begin
          ctrl_o.kind   = KIND_RELEASE;
          ctrl_o.src    = SRC_ENTRY;
          ctrl_o.remove = 1'b1;
        end else begin
          ctrl_o.clear_bytes = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // releases from the list are never the final word of a command
    ctrl_o.last = (ctrl_o.kind != KIND_RELEASE) || (ctrl_o.src == SRC_INPUT);
  end

endmodule

### hdl/fbc_dp.sv
// Datapath of the freed block cache: age-ordered entry registers, count,
// byte total, latched word and result registers. Depends on fbc_pkg.
module fbc_dp #(
  parameter int Depth       = fbc_pkg::DefDepth,
  parameter int AddressBits = fbc_pkg::DefAddressBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [AddressBits-1:0] block_address_i,
  input  logic [31:0]            block_size_i,
  input  logic                   has_platform_pool_i,
  input  logic [5:0]             max_cached_blocks_i,
  input  logic [31:0]            cached_byte_limit_i,
  input  fbc_pkg::ctrl_t         ctrl_i,
  output fbc_pkg::stat_t         stat_o,
  output logic                   result_valid_o,
  output logic [1:0]             result_kind_o,
  output logic [AddressBits-1:0] result_address_o,
  output logic [31:0]            result_size_o,
  output logic                   last_result_o
);
  import fbc_pkg::*;

  localparam int CntW = $clog2(Depth + 1);
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [AddressBits-1:0] ent_addr_q [Depth];
  logic [SizeW-1:0]       ent_size_q [Depth];
  logic [CntW-1:0]        count_q;
  logic [SizeW-1:0]       bytes_q;
  logic [IdxW-1:0]        idx_q;
  logic [AddressBits-1:0] addr_q;
  logic [SizeW-1:0]       size_q;

  logic [AddressBits-1:0] rd_addr;
  logic [SizeW-1:0]       rd_size;
  logic [SizeW:0]         sum;

  assign rd_addr = ent_addr_q[idx_q];
  assign rd_size = ent_size_q[idx_q];
  assign sum     = {1'b0, bytes_q} + {1'b0, size_q};

  always_comb begin
    stat_o.qualifies  = !has_platform_pool_i && (block_size_i <= (cached_byte_limit_i >> 2));
    stat_o.count_zero = (count_q == '0);
    // count nonzero and (count >= min(max, Depth) or bytes + size > limit); count never exceeds Depth
    stat_o.must_evict = !stat_o.count_zero &&
                        ((CapCmpW'(count_q) >= CapCmpW'(max_cached_blocks_i)) ||
                         (count_q == CntW'(Depth)) ||
                         (sum > {1'b0, cached_byte_limit_i}));
    stat_o.match      = (rd_size == size_q);
    stat_o.idx_last   = ((CntW'(idx_q) + CntW'(1)) == count_q);
    stat_o.room       = (count_q < CntW'(Depth));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      addr_q <= block_address_i;
      size_q <= block_size_i;
    end
    if (ctrl_i.remove) begin
      for (int i = 0; i + 1 < Depth; i++) begin
        if (IdxW'(i) >= idx_q) begin
          ent_addr_q[i] <= ent_addr_q[i+1];
          ent_size_q[i] <= ent_size_q[i+1];
        end
      end
    end
    if (ctrl_i.append) begin
      ent_addr_q[count_q[IdxW-1:0]] <= addr_q;
      ent_size_q[count_q[IdxW-1:0]] <= size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bytes_q <= '0;
      idx_q   <= '0;
    end else begin
      if (ctrl_i.idx_clr)      idx_q <= '0;
      else if (ctrl_i.idx_inc) idx_q <= idx_q + IdxW'(1);
      if (ctrl_i.remove) begin
        count_q <= count_q - CntW'(1);
        bytes_q <= bytes_q - rd_size;
      end else if (ctrl_i.append) begin
        count_q <= count_q + CntW'(1);
        bytes_q <= sum[SizeW-1:0];
      end else if (ctrl_i.clear_bytes) begin
        bytes_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else         result_valid_o <= ctrl_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      result_kind_o <= ctrl_i.kind;
      last_result_o <= ctrl_i.last;
      unique case (ctrl_i.src)
        SRC_INPUT: begin
          result_address_o <= block_address_i;
          result_size_o    <= block_size_i;
        end
        SRC_ENTRY: begin
          result_address_o <= rd_addr;
          result_size_o    <= (ctrl_i.kind == KIND_HIT) ? '0 : rd_size;
        end
        default: begin
          result_address_o <= '0;
          result_size_o    <= '0;
        end
      endcase
    end
  end

endmodule
